[rtl/lgs_pkg.sv]
// Shared types, command codes and rule constants for the life grid step block.
// No dependencies; used by life_grid_generation_step.
package lgs_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_STEP  = 2'd2;

   // Fixed field widths
   localparam int CMD_W   = 2;
   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;

   localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

   // B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]  size_type;

   // Next state of one cell from its old state and live neighbor count
   function automatic logic next_cell(input logic self_alive, input logic [3:0] count);
      return (count == BIRTH_COUNT) || (self_alive && (count == SURVIVE_COUNT));
   endfunction

endpackage

[rtl/life_grid_generation_step.sv]
// Sequence: a write passes through S_WR and a read through S_RD before S_DONE; a command
// whose coordinate is outside the grid goes straight to S_DONE; a step passes through S_PRIME
// and one S_ROW per row, side = min(grid_size, MAX_SIDE). One command at a time, taken again
// once the sequencer is back in idle, which it enters as its result is registered; a stalled
// result holds S_DONE until the output register is free. A step reads one row and writes one
// row per cycle in S_ROW.
// Reset (synchronous, active high) clears per-row valid bits so the whole grid reads dead
// at once; there is no clearing pass. grid_size resets to 64.
// Depends on lgs_pkg.
module life_grid_generation_step #(
   parameter int MAX_SIDE = 64
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] col, [11:6] row, [12] alive_in, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] alive_out, rest zero
   // grid_size register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int RW = $clog2(MAX_SIDE);                 // row / column index width
   localparam int SW = (RW + 1 > 7) ? RW + 1 : 7;         // width of side compares

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PRIME = 3'd1;   // first row of a step arrives
   localparam logic [2:0] S_ROW   = 3'd2;   // one new row written per cycle
   localparam logic [2:0] S_WR    = 3'd3;   // read-modify-write of one cell
   localparam logic [2:0] S_RD    = 3'd4;   // pick one cell from the row
   localparam logic [2:0] S_DONE  = 3'd5;   // hand result to output register

   // ---------------- registers ----------------
   logic [2:0]               state_ff, state_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [RW-1:0]            col_ff, col_in;
   logic                     wval_ff, wval_in;
   logic                     res_ff, res_in;
   logic [MAX_SIDE-1:0]      prev_ff, prev_in;    // old row r-1, already masked
   logic [MAX_SIDE-1:0]      cur_ff, cur_in;      // old row r, raw
   lgs_pkg::size_type        grid_size_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_data_ff, rsp_data_in;

   // ---------------- row memory ----------------
   // One row of cells per entry; synchronous read, one read and one write per cycle.
   logic [MAX_SIDE-1:0]      mem [MAX_SIDE];
   logic [MAX_SIDE-1:0]      rd_data_ff;
   logic                     rd_valid_ff;
   logic                     row_valid_ff [MAX_SIDE];  // cleared by reset: row reads dead
   logic                     mem_we, rd_en;
   logic [RW-1:0]            wr_addr, rd_addr;
   logic [MAX_SIDE-1:0]      wr_data;
   logic [MAX_SIDE-1:0]      rd_row;

   // ---------------- payload unpack ----------------
   lgs_pkg::cmd_type         req_cmd;
   lgs_pkg::coord_type       req_col, req_row;
   logic                     req_alive;

   assign req_cmd   = req_tuser;
   assign req_col   = req_tdata[5:0];
   assign req_row   = req_tdata[11:6];
   assign req_alive = req_tdata[12];

   // ---------------- geometry ----------------
   logic [SW-1:0]            side;
   logic [MAX_SIDE-1:0]      col_mask;      // columns inside the active square
   logic                     req_inside;
   logic [SW-1:0]            row_nx1, row_nx2;

   assign side = (SW'(grid_size_ff) > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(grid_size_ff);
   assign req_inside = (SW'(req_col) < side) && (SW'(req_row) < side);
   assign row_nx1 = SW'(row_ff) + SW'(1);
   assign row_nx2 = SW'(row_ff) + SW'(2);

   always_comb begin
      for (int c = 0; c < MAX_SIDE; c++) begin
         col_mask[c] = (SW'(c) < side);
      end
   end

   // rows never written since reset read as dead
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

   // ---------------- next generation of one row ----------------
   logic [MAX_SIDE-1:0]      cur_m, nxt_m, gen_row;
   logic [MAX_SIDE+1:0]      p_pad, c_pad, n_pad;

   assign cur_m = cur_ff & col_mask;
   // row below is dead when it lies past the bottom edge
   assign nxt_m = (row_nx1 < side) ? (rd_row & col_mask) : '0;
   assign p_pad = {1'b0, prev_ff, 1'b0};
   assign c_pad = {1'b0, cur_m, 1'b0};
   assign n_pad = {1'b0, nxt_m, 1'b0};

   always_comb begin
      logic [3:0] cnt;
      for (int c = 0; c < MAX_SIDE; c++) begin
         cnt = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
             + 4'(c_pad[c])                  + 4'(c_pad[c+2])
             + 4'(n_pad[c]) + 4'(n_pad[c+1]) + 4'(n_pad[c+2]);
         gen_row[c] = lgs_pkg::next_cell(cur_m[c], cnt);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wval_in      = wval_ff;
      res_in       = res_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      wr_addr      = row_ff;
      wr_data      = rd_row;
      rd_en        = 1'b0;
      rd_addr      = RW'(req_row);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               row_in   = RW'(req_row);
               col_in   = RW'(req_col);
               wval_in  = req_alive;
               res_in   = 1'b0;
               state_in = S_DONE;     // ignored commands answer 0 directly
               unique case (req_cmd)
                  lgs_pkg::CMD_WRITE: begin
                     if (req_inside) begin
                        rd_en    = 1'b1;
                        state_in = S_WR;
                     end
                  end
                  lgs_pkg::CMD_READ: begin
                     if (req_inside) begin
                        rd_en    = 1'b1;
                        state_in = S_RD;
                     end
                  end
                  lgs_pkg::CMD_STEP: begin
                     if (side != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        row_in   = '0;
                        state_in = S_PRIME;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PRIME: begin
            cur_in  = rd_row;
            prev_in = '0;                // above the top edge
            if (SW'(1) < side) begin
               rd_en   = 1'b1;
               rd_addr = RW'(1);
            end
            state_in = S_ROW;
         end
         S_ROW: begin
            // new row inside the square, old cells outside kept as they were
            mem_we  = 1'b1;
            wr_data = (gen_row & col_mask) | (cur_ff & ~col_mask);
            prev_in = cur_m;
            cur_in  = rd_row;
            row_in  = RW'(row_nx1);
            if (row_nx2 < side) begin
               rd_en   = 1'b1;
               rd_addr = RW'(row_nx2);
            end
            if (row_nx1 >= side) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_WR: begin
            mem_we           = 1'b1;
            wr_data[col_ff]  = wval_ff;
            state_in         = S_DONE;
         end
         S_RD: begin
            res_in   = rd_row[col_ff];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         grid_size_ff <= lgs_pkg::GRID_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            grid_size_ff <= csr_wr_data;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      wval_ff     <= wval_in;
      res_ff      <= res_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   // row memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SIDE; i++) begin
            row_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (mem_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // ---------------- outputs ----------------
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

   // ---------------- assertions ----------------
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_WR || state_ff == S_ROW))
      else $error("row memory written outside a write or step");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> (SW'(row_ff) < side))
      else $error("step row beyond active side");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted transaction left no work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result issued outside completion state");

endmodule
